>>> rtl/gpms_pkg.sv
// Package with the types, codes and constants of the go-to-point motion sequencer.
package gpms_pkg;

  // Configuration register reset values.
  localparam logic [15:0] StopDistanceRst    = 16'd300;
  localparam logic [15:0] RestartDistanceRst = 16'd400;
  localparam logic [15:0] WaitTimeMsRst      = 16'd3000;

  typedef enum logic [1:0] {
    CFG_STOP_DISTANCE    = 2'd0,
    CFG_RESTART_DISTANCE = 2'd1,
    CFG_WAIT_TIME_MS     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_LOOK = 2'd1,
    OP_MOVE = 2'd2,
    OP_TURN = 2'd3
  } outer_phase_e;

  typedef enum logic [2:0] {
    MP_INIT  = 3'd0,
    MP_FIRST = 3'd1,
    MP_MOVE  = 3'd2,
    MP_STOP  = 3'd3,
    MP_WAIT  = 3'd4
  } move_phase_e;

  typedef enum logic [1:0] {
    LOOK_NONE     = 2'd0,
    LOOK_FORWARD  = 2'd1,
    LOOK_BACKWARD = 2'd2
  } look_e;

  typedef enum logic [1:0] {
    BRAKE_NONE    = 2'd0,
    BRAKE_ENGAGE  = 2'd1,
    BRAKE_RELEASE = 2'd2
  } brake_e;

  typedef enum logic [1:0] {
    STATUS_RUNNING = 2'd0,
    STATUS_SUCCESS = 2'd1,
    STATUS_FAILED  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] stop_distance;
    logic [15:0] restart_distance;
    logic [15:0] wait_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        obstacle_distance;
    logic [31:0]        now_ms;
    logic               angular_settled;
    logic               linear_settled;
    logic               braking_nonzero;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_heading;
    logic               move_backward;
    logic               turn_side;
    logic               final_turn;
  } req_t;

  typedef struct packed {
    logic [1:0]         look_cmd;
    logic               linear_cmd;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic               angular_cmd;
    logic signed [15:0] cmd_heading;
    logic               cmd_side;
    logic               stop_cmd;
    logic [1:0]         brake_cmd;
    logic               enable_cmd;
    logic [1:0]         status;
  } rsp_t;

endpackage

>>> rtl/gpms_cfg_regs.sv
// Configuration register file of the go-to-point motion sequencer.
module gpms_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output gpms_pkg::cfg_t    cfg_o
);

  gpms_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpms_pkg::CFG_STOP_DISTANCE:    cfg_d.stop_distance    = cfg_wdata_i;
        gpms_pkg::CFG_RESTART_DISTANCE: cfg_d.restart_distance = cfg_wdata_i;
        gpms_pkg::CFG_WAIT_TIME_MS:     cfg_d.wait_time_ms     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_distance    <= gpms_pkg::StopDistanceRst;
      cfg_q.restart_distance <= gpms_pkg::RestartDistanceRst;
      cfg_q.wait_time_ms     <= gpms_pkg::WaitTimeMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/gpms_step.sv
// Sequencer state and the per-request step logic of the go-to-point motion sequencer.
module gpms_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  gpms_pkg::cfg_t cfg_i,
  input  gpms_pkg::req_t req_i,
  output gpms_pkg::rsp_t rsp_o
);

  gpms_pkg::outer_phase_e outer_q, outer_d;
  logic                   entry_q, entry_d;
  gpms_pkg::move_phase_e  move_q, move_d;
  logic signed [15:0]     lx_q, lx_d, ly_q, ly_d;
  logic [31:0]            deadline_q, deadline_d;

  logic        blocked;
  logic        move_ok;
  logic        move_fail;
  logic [31:0] new_deadline;

  assign blocked      = req_i.obstacle_distance < cfg_i.stop_distance;
  assign new_deadline = req_i.now_ms + {16'd0, cfg_i.wait_time_ms};

  always_comb begin
    rsp_o      = '0;
    outer_d    = outer_q;
    move_d     = move_q;
    lx_d       = lx_q;
    ly_d       = ly_q;
    deadline_d = deadline_q;
    move_ok    = 1'b0;
    move_fail  = 1'b0;

    unique case (outer_q)
      gpms_pkg::OP_INIT: begin
        outer_d = gpms_pkg::OP_LOOK;
      end
      gpms_pkg::OP_LOOK: begin
        if (entry_q) begin
          rsp_o.look_cmd = req_i.move_backward ? gpms_pkg::LOOK_BACKWARD
                                               : gpms_pkg::LOOK_FORWARD;
          rsp_o.cmd_x    = req_i.target_x;
          rsp_o.cmd_y    = req_i.target_y;
        end
        if (req_i.angular_settled) begin
          outer_d = gpms_pkg::OP_MOVE;
        end
      end
      gpms_pkg::OP_MOVE: begin
        unique case (move_q)
          gpms_pkg::MP_INIT: begin
            // The target is latched here and sent out in the same cycle.
            lx_d             = req_i.target_x;
            ly_d             = req_i.target_y;
            rsp_o.linear_cmd = 1'b1;
            rsp_o.cmd_x      = req_i.target_x;
            rsp_o.cmd_y      = req_i.target_y;
            move_d           = gpms_pkg::MP_FIRST;
          end
          gpms_pkg::MP_FIRST: begin
            if (req_i.braking_nonzero) begin
              if (blocked) begin
                deadline_d = new_deadline;
                move_d     = gpms_pkg::MP_WAIT;
              end else begin
                rsp_o.linear_cmd = 1'b1;
                rsp_o.cmd_x      = lx_q;
                rsp_o.cmd_y      = ly_q;
                move_d           = gpms_pkg::MP_MOVE;
              end
            end
          end
          gpms_pkg::MP_MOVE: begin
            // An obstacle wins over arrival.
            if (blocked) begin
              rsp_o.stop_cmd  = 1'b1;
              rsp_o.brake_cmd = gpms_pkg::BRAKE_ENGAGE;
              move_d          = gpms_pkg::MP_STOP;
            end else if (req_i.linear_settled) begin
              move_d  = gpms_pkg::MP_INIT;
              move_ok = 1'b1;
            end
          end
          gpms_pkg::MP_STOP: begin
            if (!req_i.braking_nonzero) begin
              deadline_d = new_deadline;
              move_d     = gpms_pkg::MP_WAIT;
            end
          end
          gpms_pkg::MP_WAIT: begin
            // Clearance wins over an expired deadline; both resume the motors.
            if (req_i.obstacle_distance > cfg_i.restart_distance) begin
              rsp_o.brake_cmd  = gpms_pkg::BRAKE_RELEASE;
              rsp_o.enable_cmd = 1'b1;
              rsp_o.linear_cmd = 1'b1;
              rsp_o.cmd_x      = lx_q;
              rsp_o.cmd_y      = ly_q;
              move_d           = gpms_pkg::MP_MOVE;
            end else if (deadline_q < req_i.now_ms) begin
              rsp_o.brake_cmd  = gpms_pkg::BRAKE_RELEASE;
              rsp_o.enable_cmd = 1'b1;
              rsp_o.linear_cmd = 1'b1;
              rsp_o.cmd_x      = lx_q;
              rsp_o.cmd_y      = ly_q;
              move_d           = gpms_pkg::MP_INIT;
              move_fail        = 1'b1;
            end
          end
          default: begin
            move_d = gpms_pkg::MP_INIT;
          end
        endcase

        if (move_ok) begin
          if (req_i.final_turn) begin
            outer_d = gpms_pkg::OP_TURN;
          end else begin
            outer_d      = gpms_pkg::OP_INIT;
            rsp_o.status = gpms_pkg::STATUS_SUCCESS;
          end
        end else if (move_fail) begin
          outer_d      = gpms_pkg::OP_INIT;
          rsp_o.status = gpms_pkg::STATUS_FAILED;
        end
      end
      gpms_pkg::OP_TURN: begin
        if (entry_q) begin
          rsp_o.angular_cmd = 1'b1;
          rsp_o.cmd_heading = req_i.target_heading;
          rsp_o.cmd_side    = req_i.turn_side;
        end
        if (req_i.angular_settled) begin
          outer_d      = gpms_pkg::OP_INIT;
          rsp_o.status = gpms_pkg::STATUS_SUCCESS;
        end
      end
      default: begin
        outer_d = gpms_pkg::OP_INIT;
      end
    endcase

    entry_d = (outer_d != outer_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q    <= gpms_pkg::OP_INIT;
      entry_q    <= 1'b1;
      move_q     <= gpms_pkg::MP_INIT;
      lx_q       <= '0;
      ly_q       <= '0;
      deadline_q <= '0;
    end else if (step_i) begin
      outer_q    <= outer_d;
      entry_q    <= entry_d;
      move_q     <= move_d;
      lx_q       <= lx_d;
      ly_q       <= ly_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

>>> rtl/goto_point_motion_sequencer.sv
// Top level of the go-to-point motion sequencer: request and result registers around the step logic.
// An accepted request waits in the request register; its result then waits in the result register.
// Throughput: one request per cycle while out_ready_i stays high; the step logic between the request
// and result registers advances once per request, so back-to-back requests flow without gaps.
// Reset (rst_ni low, asynchronous) empties both registers, sets the configuration to
// stop 300, restart 400, wait 3000 ms, and puts the sequencer in its init phase.
module goto_point_motion_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Request channel.
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gpms_pkg::req_t in_req_i,
  // Result channel.
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gpms_pkg::rsp_t out_rsp_o,
  // Configuration write port.
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  gpms_pkg::cfg_t cfg;
  gpms_pkg::rsp_t step_rsp;

  logic           req_valid_q, req_valid_d;
  gpms_pkg::req_t req_q;
  logic           rsp_valid_q, rsp_valid_d;
  gpms_pkg::rsp_t rsp_q;
  logic           advance;

  // The held request moves on whenever the result register is empty or is being
  // drained this cycle. The request register refills in the same cycle, but a stalled
  // result blocks the next request whenever the request register is still full.
  assign advance     = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;

  assign req_valid_d = (in_valid_i && in_ready_o) || (req_valid_q && !advance);
  assign rsp_valid_d = advance || (rsp_valid_q && !out_ready_i);

  gpms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The sequencer state only moves when a request is actually processed.
  gpms_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .req_i  (req_q),
    .rsp_o  (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> rtl/gpms_checker.sv
// Port-level checker of the go-to-point motion sequencer and its bind statement.
module gpms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input gpms_pkg::rsp_t out_rsp_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // A failed move always resumes the motors and reissues the linear setpoint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == gpms_pkg::STATUS_FAILED |->
      out_rsp_o.brake_cmd == gpms_pkg::BRAKE_RELEASE && out_rsp_o.enable_cmd &&
      out_rsp_o.linear_cmd)
    else $error("failure without resume commands");

  // A stop always comes with the brake engaged and never with a new setpoint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.stop_cmd |->
      out_rsp_o.brake_cmd == gpms_pkg::BRAKE_ENGAGE && !out_rsp_o.linear_cmd &&
      out_rsp_o.status == gpms_pkg::STATUS_RUNNING)
    else $error("stop without brake engage");

  // A look request excludes linear and angular setpoints in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.look_cmd != gpms_pkg::LOOK_NONE |->
      !out_rsp_o.linear_cmd && !out_rsp_o.angular_cmd)
    else $error("look mixed with another setpoint");

  // Coordinates are zero when no look or linear command uses them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.linear_cmd && out_rsp_o.look_cmd == gpms_pkg::LOOK_NONE |->
      out_rsp_o.cmd_x == '0 && out_rsp_o.cmd_y == '0)
    else $error("idle coordinates not zero");

endmodule

bind goto_point_motion_sequencer gpms_checker u_gpms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for the go-to-point motion sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpms_pkg::*;

  // The watchdog ends the run after this many cycles in which neither channel moved.
  localparam int StallLimit = 2000;
  // Random requests per limit setting; five settings give about 700 requests.
  localparam int PhaseRequests = 140;

  // Scoreboard with its own copy of the sequencer state. Every accepted request yields
  // exactly one expected command set, kept in order until the matching result shows up.
  class sequencer_checker;
    logic [15:0]  lim_stop, lim_restart, lim_wait;
    outer_phase_e phase;
    bit           fresh;
    move_phase_e  leg;
    logic [15:0]  goal_x, goal_y;
    logic [31:0]  deadline;
    rsp_t         pending_cmds[$];
    int           errors, requests, results;
    int           n_success, n_failed, n_halts, n_resumes, n_turns;

    function new();
      lim_stop    = StopDistanceRst;
      lim_restart = RestartDistanceRst;
      lim_wait    = WaitTimeMsRst;
      phase       = OP_INIT;
      fresh       = 1'b1;
      leg         = MP_INIT;
      goal_x      = '0;
      goal_y      = '0;
      deadline    = '0;
    endfunction

    function void set_limits(logic [15:0] s, logic [15:0] r, logic [15:0] w);
      lim_stop    = s;
      lim_restart = r;
      lim_wait    = w;
    endfunction

    function void aim_linear(inout rsp_t o);
      o.linear_cmd = 1'b1;
      o.cmd_x      = goal_x;
      o.cmd_y      = goal_y;
    endfunction

    function void release_brake(inout rsp_t o);
      o.brake_cmd  = BRAKE_RELEASE;
      o.enable_cmd = 1'b1;
      aim_linear(o);
      n_resumes++;
    endfunction

    // One tick of the straight-move leg: +1 on arrival, -1 on a clearance timeout.
    function int move_leg(req_t q, inout rsp_t o);
      logic blocked;
      int   outcome;
      blocked = q.obstacle_distance < lim_stop;
      outcome = 0;
      case (leg)
        MP_INIT: begin
          goal_x = q.target_x;
          goal_y = q.target_y;
          aim_linear(o);
          leg = MP_FIRST;
        end
        MP_FIRST: begin
          if (q.braking_nonzero) begin
            if (blocked) begin
              deadline = q.now_ms + lim_wait;
              leg      = MP_WAIT;
            end else begin
              aim_linear(o);
              leg = MP_MOVE;
            end
          end
        end
        MP_MOVE: begin
          // An obstacle wins over a settled linear controller.
          if (blocked) begin
            o.stop_cmd  = 1'b1;
            o.brake_cmd = BRAKE_ENGAGE;
            leg         = MP_STOP;
            n_halts++;
          end else if (q.linear_settled) begin
            leg     = MP_INIT;
            outcome = 1;
          end
        end
        MP_STOP: begin
          if (!q.braking_nonzero) begin
            deadline = q.now_ms + lim_wait;
            leg      = MP_WAIT;
          end
        end
        MP_WAIT: begin
          // Clearance wins over an expired deadline.
          if (q.obstacle_distance > lim_restart) begin
            release_brake(o);
            leg = MP_MOVE;
          end else if (deadline < q.now_ms) begin
            release_brake(o);
            leg     = MP_INIT;
            outcome = -1;
          end
        end
        default: leg = MP_INIT;
      endcase
      return outcome;
    endfunction

    function rsp_t predict_cmds(req_t q);
      rsp_t         o;
      outer_phase_e nxt;
      int           outcome;
      o      = '0;
      o.status = STATUS_RUNNING;
      nxt    = phase;
      case (phase)
        OP_INIT: nxt = OP_LOOK;
        OP_LOOK: begin
          if (fresh) begin
            o.look_cmd = q.move_backward ? LOOK_BACKWARD : LOOK_FORWARD;
            o.cmd_x    = q.target_x;
            o.cmd_y    = q.target_y;
          end
          if (q.angular_settled) nxt = OP_MOVE;
        end
        OP_MOVE: begin
          outcome = move_leg(q, o);
          if (outcome > 0) begin
            if (q.final_turn) begin
              nxt = OP_TURN;
            end else begin
              nxt      = OP_INIT;
              o.status = STATUS_SUCCESS;
            end
          end else if (outcome < 0) begin
            nxt      = OP_INIT;
            o.status = STATUS_FAILED;
          end
        end
        default: begin
          if (fresh) begin
            o.angular_cmd = 1'b1;
            o.cmd_heading = q.target_heading;
            o.cmd_side    = q.turn_side;
            n_turns++;
          end
          if (q.angular_settled) begin
            nxt      = OP_INIT;
            o.status = STATUS_SUCCESS;
          end
        end
      endcase
      if (o.status == STATUS_SUCCESS) n_success++;
      if (o.status == STATUS_FAILED) n_failed++;
      fresh = (nxt != phase);
      phase = nxt;
      return o;
    endfunction

    function void note_request(req_t q);
      pending_cmds.push_back(predict_cmds(q));
      requests++;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("MISMATCH result %0d %s: expected %0h, actual %0h",
                   results, field, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("MISMATCH unexpected result with nothing outstanding: %p", got);
      end else begin
        want = pending_cmds.pop_front();
        compare_field("look_cmd", want.look_cmd, got.look_cmd);
        compare_field("linear_cmd", want.linear_cmd, got.linear_cmd);
        compare_field("cmd_x", want.cmd_x, got.cmd_x);
        compare_field("cmd_y", want.cmd_y, got.cmd_y);
        compare_field("angular_cmd", want.angular_cmd, got.angular_cmd);
        compare_field("cmd_heading", want.cmd_heading, got.cmd_heading);
        compare_field("cmd_side", want.cmd_side, got.cmd_side);
        compare_field("stop_cmd", want.stop_cmd, got.stop_cmd);
        compare_field("brake_cmd", want.brake_cmd, got.brake_cmd);
        compare_field("enable_cmd", want.enable_cmd, got.enable_cmd);
        compare_field("status", want.status, got.status);
      end
      results++;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  req_t       in_req_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rsp_t       out_rsp_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_STOP_DISTANCE;
  logic [15:0] cfg_wdata_i = '0;

  sequencer_checker chk = new();

  // While set, neither side inserts idle cycles, so requests stream back to back.
  bit steady = 1'b0;
  // Millisecond counter fed to the block; it mostly creeps forward but also jumps and wraps.
  logic [31:0] clock_ms = '0;
  int stall_cycles = 0;

  goto_point_motion_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The result side stalls at random with a probability of 27 percent unless a steady stretch is running.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 27);
  end

  // All outputs are sampled right at the edge, before any register of the block updates,
  // so a result is taken exactly when valid and ready were both high at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) chk.check_result(out_rsp_o);
  end

  // Watchdog: counts cycles in which no request and no result moved.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TIMEOUT: nothing moved for %0d cycles, %0d results still outstanding",
               stall_cycles, chk.pending_cmds.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. Random idle cycles go
  // in front, so gaps land in every phase of the sequencer.
  task automatic send_req(input req_t r);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chk.note_request(r);
  endtask

  // Stops sending and waits until every expected result has arrived, then lets the
  // two-stage pipeline settle.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (chk.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three limit registers, one per cycle, while the block is idle.
  task automatic program_limits(input logic [15:0] s, input logic [15:0] r,
                                input logic [15:0] w);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_STOP_DISTANCE;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RESTART_DISTANCE;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_WAIT_TIME_MS;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chk.set_limits(s, r, w);
  endtask

  function automatic req_t build_req(logic [15:0] obs_dist, logic [31:0] now_ms, bit ang,
                                     bit lin, bit brk, logic [15:0] x, logic [15:0] y,
                                     logic [15:0] hd, bit back, bit side, bit fin);
    req_t r;
    r.obstacle_distance = obs_dist;
    r.now_ms            = now_ms;
    r.angular_settled   = ang;
    r.linear_settled    = lin;
    r.braking_nonzero   = brk;
    r.target_x          = x;
    r.target_y          = y;
    r.target_heading    = hd;
    r.move_backward     = back;
    r.turn_side         = side;
    r.final_turn        = fin;
    return r;
  endfunction

  // Random tick. The obstacle distance is steered around the current stop and restart
  // limits so that halts, waits, resumes and timeouts all happen often; the clock
  // sometimes leaps past the wait time so that deadlines really expire.
  function automatic req_t random_req();
    req_t        r;
    int unsigned lo;
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2, 3: begin
        lo = (chk.lim_restart == 16'hFFFF) ? 65535 : chk.lim_restart + 1;
        r.obstacle_distance = $urandom_range(65535, lo);
      end
      4, 5: r.obstacle_distance = (chk.lim_stop == 0) ? 0 : $urandom_range(chk.lim_stop - 1, 0);
      6: r.obstacle_distance = $urandom_range(chk.lim_restart, chk.lim_stop);
      7: begin
        case ($urandom_range(3))
          0: r.obstacle_distance = chk.lim_stop;
          1: r.obstacle_distance = chk.lim_stop - 16'd1;
          2: r.obstacle_distance = chk.lim_restart;
          default: r.obstacle_distance = chk.lim_restart + 16'd1;
        endcase
      end
      default: r.obstacle_distance = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 70) clock_ms = clock_ms + $urandom_range(200);
    else if (pick < 85) clock_ms = clock_ms + chk.lim_wait + $urandom_range(3);
    else if (pick < 90) clock_ms = $urandom;
    else if (pick < 95) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    r.now_ms          = clock_ms;
    r.angular_settled = ($urandom_range(99) < 40);
    r.linear_settled  = ($urandom_range(99) < 35);
    r.braking_nonzero = $urandom_range(1);
    r.target_x        = $urandom;
    r.target_y        = $urandom;
    r.target_heading  = $urandom;
    r.move_backward   = $urandom_range(1);
    r.turn_side       = $urandom_range(1);
    r.final_turn      = $urandom_range(1);
    return r;
  endfunction

  // One block of random requests under one limit setting. Halfway through, the sender
  // holds off until every outstanding result is back.
  task automatic run_random_phase(input logic [15:0] s, input logic [15:0] r,
                                  input logic [15:0] w, input bit calm);
    drain_requests();
    program_limits(s, r, w);
    for (int i = 0; i < PhaseRequests; i++) begin
      steady = calm && (i < 100);
      send_req(random_req());
      if (i == PhaseRequests / 2) drain_requests();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through the sequencer under the reset limits (300, 400, 3000 ms).
    // Argument order: distance, time, angular, linear, braking, x, y, heading,
    // backward, side, final turn.
    send_req(build_req(16'h0000, 32'h0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    // Look backward on entry, targets at both extremes; not yet settled.
    send_req(build_req(16'hFFFF, 32'h10, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0000, 1, 0, 0));
    send_req(build_req(16'hFFFF, 32'h20, 1, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    // Move start latches the opposite extremes.
    send_req(build_req(16'h1000, 32'h30, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'h1000, 32'h40, 1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd1000, 32'h50, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    // Obstacle and settled linear controller on the same tick: the halt must win.
    send_req(build_req(16'd0, 32'h60, 0, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd0, 32'h70, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd0, 32'd100, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    // Clearance and an expired deadline together: the move must resume, not fail.
    send_req(build_req(16'd401, 32'd5000, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'hFFFF, 32'd5010, 0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1));
    // Closing turn: the angular command goes out on entry only.
    send_req(build_req(16'd0, 32'd5020, 0, 0, 0, 16'h0000, 16'h0000, 16'h8000, 0, 1, 0));
    send_req(build_req(16'd0, 32'd5030, 1, 0, 0, 16'h0000, 16'h0000, 16'h7FFF, 0, 0, 0));
    send_req(build_req(16'd0, 32'd5040, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    // Look forward and leave the look phase on the same tick.
    send_req(build_req(16'd500, 32'hFFFF_FF00, 1, 0, 0, 16'h1234, 16'hFEDC, 16'h0, 0, 0, 0));
    send_req(build_req(16'd500, 32'hFFFF_FF00, 0, 0, 0, 16'hFFFF, 16'h0001, 16'h0, 0, 0, 0));
    // Blocked on the first braking tick near the top of the clock: the deadline wraps.
    send_req(build_req(16'd299, 32'hFFFF_FF00, 0, 0, 1, 16'h0000, 16'h0000, 16'h0, 0, 0, 0));
    // Deadline equal to the time is not yet expired; a later time makes it fail.
    send_req(build_req(16'd400, 32'h0000_0AB8, 0, 0, 0, 16'h0000, 16'h0000, 16'h0, 0, 0, 0));
    send_req(build_req(16'd400, 32'hFFFF_FFFF, 0, 0, 0, 16'h0000, 16'h0000, 16'h0, 0, 0, 0));
    send_req(build_req(16'd400, 32'd0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd400, 32'd1, 1, 0, 0, 16'h0042, 16'hFF00, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd400, 32'd2, 0, 0, 0, 16'h0042, 16'hFF00, 16'h0000, 0, 0, 0));
    // Distance equal to the stop limit is not an obstacle; arrival without a turn.
    send_req(build_req(16'd300, 32'd3, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    send_req(build_req(16'd300, 32'd4, 0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0));

    // Random requests under several limit settings, the extremes among them. The
    // fourth setting puts the restart distance below the stop distance.
    run_random_phase(16'd300, 16'd400, 16'd3000, 1'b1);
    run_random_phase(16'd0, 16'd0, 16'd0, 1'b0);
    run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random_phase(16'd1000, 16'd500, 16'd10, 1'b0);
    run_random_phase($urandom, $urandom, $urandom_range(5000), 1'b0);

    drain_requests();
    if (chk.pending_cmds.size() != 0) chk.errors++;

    $display("Covered %0d requests under five limit settings with random stalls on both sides.",
             chk.requests);
    $display("Saw %0d successes, %0d failures, %0d halts, %0d resumes, %0d closing turns.",
             chk.n_success, chk.n_failed, chk.n_halts, chk.n_resumes, chk.n_turns);
    if (chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
